// File: hdl/ilpd_pkg.sv
// ----------------------------------------------------------------------------
// ilpd_pkg: shared types and codes for the ID/length packet deframer
// Frame phases, sequencer states, result status codes, register indexes.
// ----------------------------------------------------------------------------
package ilpd_pkg;

   // frame parsing phase
   typedef enum logic [1:0] {
      PH_HUNT,
      PH_ID,
      PH_DATA,
      PH_SUM
   } phase_type;

   // sequencer state
   typedef enum logic [1:0] {
      SQ_READY,   // waiting for a transfer
      SQ_SCAN,    // walking the ID table, one slot per cycle
      SQ_FETCH,   // buffer read in flight
      SQ_SEND     // load a data byte into the output register
   } seq_type;

   // result status
   typedef enum logic [2:0] {
      STAT_DATA,
      STAT_EMPTY,
      STAT_BADSUM,
      STAT_UNKNOWN,
      STAT_TIMEOUT
   } status_type;

   // input kinds
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // register indexes
   localparam logic [2:0] CSR_START_BYTE    = 3'd0;
   localparam logic [2:0] CSR_MESSAGE_COUNT = 3'd1;
   localparam logic [2:0] CSR_ID_TABLE      = 3'd2;
   localparam logic [2:0] CSR_LENGTH_TABLE  = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT_TICKS = 3'd4;

   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

endpackage

// File: hdl/ilpd_buffer.sv
// ----------------------------------------------------------------------------
// ilpd_buffer: frame data buffer
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ilpd_buffer #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/id_length_packet_deframer.sv
// ----------------------------------------------------------------------------
// id_length_packet_deframer: start byte / ID / length deframer
// Hunts for a start byte, looks up the message ID, buffers the data bytes
// with an 8-bit additive checksum and delivers the frame on a match.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries received bytes (tuser = 0) and time ticks (tuser = 1).
//   rsp_*  carries results: data bytes of a good frame as a run closed by
//          tlast, or one status transfer (empty frame, checksum error,
//          unknown ID, inter-byte timeout).
//   csr_*  writes the start byte, table size, ID/length tables and timeout.
// Flow: ticks, start bytes and data bytes are taken back to back while
//   the output register is free. An ID byte holds the input while one
//   shared comparator walks the ID table one slot per cycle. A good frame
//   is delivered through the single buffer read port, each byte read,
//   then loaded into the output register.
// Status: a status result is in the output register in the cycle after the
//   transfer that caused it (unknown ID: after the table walk).
// Reset: synchronous; hunting for the start byte, registers at defaults.
// Stalls: with rsp_tready low the output register holds its result and
//   req_tready drops until it drains; no result is lost.
// ----------------------------------------------------------------------------
module id_length_packet_deframer
   import ilpd_pkg::*;
#(
   parameter int MAX_MESSAGES = 8,   // 1..8
   parameter int MAX_DATA_LEN = 32   // 1..64
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  logic        req_tuser,    // [0] command
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [2:0] msg_index, [10:3] payload_byte
   output logic [2:0]  rsp_tuser,    // [2:0] status
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_DATA_LEN + 1);
   localparam int AW    = (MAX_DATA_LEN > 1) ? $clog2(MAX_DATA_LEN) : 1;
   localparam logic [7:0]       MAX_LEN8 = 8'(MAX_DATA_LEN);
   localparam logic [CNT_W-1:0] MAX_LENC = CNT_W'(MAX_DATA_LEN);
   localparam logic [3:0]       MAX_MSG4 = 4'(MAX_MESSAGES);

   // byte 'slot' of a packed 64-bit table
   function automatic logic [7:0] table_byte(input logic [63:0] tab,
                                             input logic [2:0] slot);
      return tab[{slot, 3'b000} +: 8];
   endfunction

   // configuration registers
   logic [7:0]  start_ff;
   logic [3:0]  msg_count_ff;
   logic [63:0] id_tab_ff;
   logic [63:0] len_tab_ff;
   logic [15:0] timeout_ff;

   // frame state
   phase_type        phase_ff, phase_in;
   seq_type          seq_ff, seq_in;
   logic [2:0]       slot_ff, slot_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [15:0]      idle_ff, idle_in;
   logic [7:0]       id_byte_ff, id_byte_in;
   logic [3:0]       scan_ff, scan_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [2:0] rsp_index_ff, rsp_index_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   // buffer port
   logic       mem_we;
   logic       mem_re;
   logic [7:0] mem_rd_data;

   // datapath helpers
   logic             out_free;
   logic             accept;
   logic [3:0]       n_msgs;
   logic [7:0]       len8;
   logic [CNT_W-1:0] len_sat;
   logic [CNT_W-1:0] count_inc;
   logic [16:0]      tick_next;
   logic             scan_hit;
   logic [4:0]       scan_inc;

   // ---------------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         msg_count_ff <= '0;
         id_tab_ff    <= '0;
         len_tab_ff   <= '0;
         timeout_ff   <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_BYTE:    start_ff     <= csr_wdata[7:0];
            CSR_MESSAGE_COUNT: msg_count_ff <= csr_wdata[3:0];
            CSR_ID_TABLE:      id_tab_ff    <= csr_wdata;
            CSR_LENGTH_TABLE:  len_tab_ff   <= csr_wdata;
            CSR_TIMEOUT_TICKS: timeout_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // helpers
   // ---------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (seq_ff == SQ_READY) && out_free;
   assign accept     = req_tvalid && req_tready;

   // table size above the slot count acts as the slot count
   assign n_msgs = (msg_count_ff > MAX_MSG4) ? MAX_MSG4 : msg_count_ff;

   // current slot length, saturated to the buffer depth
   assign len8    = table_byte(len_tab_ff, slot_ff);
   assign len_sat = (len8 > MAX_LEN8) ? MAX_LENC : len8[CNT_W-1:0];

   assign count_inc = count_ff + CNT_W'(1);
   assign tick_next = {1'b0, idle_ff} + 17'd1;

   // shared comparator for the table walk
   assign scan_hit = (scan_ff < n_msgs) &&
                     (table_byte(id_tab_ff, scan_ff[2:0]) == id_byte_ff);
   assign scan_inc = {1'b0, scan_ff} + 5'd1;

   // ---------------------------------------------------------------------
   // sequencer: next state and outputs
   // ---------------------------------------------------------------------
   always_comb begin
      logic do_check;

      do_check      = 1'b0;
      phase_in      = phase_ff;
      seq_in        = seq_ff;
      slot_in       = slot_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      idle_in       = idle_ff;
      id_byte_in    = id_byte_ff;
      scan_in       = scan_ff;
      rd_idx_in     = rd_idx_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;

      case (seq_ff)
         SQ_READY: begin
            if (accept) begin
               if (req_tuser == CMD_TICK) begin
                  // ticks only count inside a frame
                  if (phase_ff != PH_HUNT) begin
                     if (tick_next > {1'b0, timeout_ff}) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_TIMEOUT;
                        rsp_index_in  = (phase_ff == PH_ID) ? 3'd0 : slot_ff;
                        rsp_byte_in   = '0;
                        rsp_last_in   = 1'b1;
                        phase_in      = PH_HUNT;
                        idle_in       = '0;
                     end else begin
                        idle_in = tick_next[15:0];
                     end
                  end
               end else begin
                  idle_in = '0;
                  case (phase_ff)
                     PH_HUNT: begin
                        if (req_tdata == start_ff) begin
                           phase_in = PH_ID;
                        end
                     end
                     PH_ID: begin
                        id_byte_in = req_tdata;
                        scan_in    = '0;
                        seq_in     = SQ_SCAN;
                     end
                     PH_DATA: begin
                        // length re-read each byte; a full count makes
                        // this byte the checksum
                        if (count_ff >= len_sat) begin
                           do_check = 1'b1;
                        end else begin
                           mem_we   = 1'b1;
                           count_in = count_inc;
                           sum_in   = sum_ff + req_tdata;
                           if (count_inc >= len_sat) begin
                              phase_in = PH_SUM;
                           end
                        end
                     end
                     default: begin
                        do_check = 1'b1;
                     end
                  endcase

                  if (do_check) begin
                     phase_in = PH_HUNT;
                     if (req_tdata != sum_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_BADSUM;
                        rsp_index_in  = slot_ff;
                        rsp_byte_in   = '0;
                        rsp_last_in   = 1'b1;
                     end else if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        rsp_index_in  = slot_ff;
                        rsp_byte_in   = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        rd_idx_in = '0;
                        seq_in    = SQ_FETCH;
                     end
                  end
               end
            end
         end

         SQ_SCAN: begin
            // lowest matching slot wins
            if (scan_hit) begin
               slot_in  = scan_ff[2:0];
               count_in = '0;
               sum_in   = '0;
               phase_in = (table_byte(len_tab_ff, scan_ff[2:0]) == 8'd0) ?
                          PH_SUM : PH_DATA;
               seq_in   = SQ_READY;
            end else if (scan_inc >= {1'b0, n_msgs}) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_UNKNOWN;
                  rsp_index_in  = '0;
                  rsp_byte_in   = '0;
                  rsp_last_in   = 1'b1;
                  phase_in      = PH_HUNT;
                  seq_in        = SQ_READY;
               end
            end else begin
               scan_in = scan_inc[3:0];
            end
         end

         SQ_FETCH: begin
            mem_re = 1'b1;
            seq_in = SQ_SEND;
         end

         SQ_SEND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_DATA;
               rsp_index_in  = slot_ff;
               rsp_byte_in   = mem_rd_data;
               rsp_last_in   = ((rd_idx_ff + CNT_W'(1)) == count_ff);
               if ((rd_idx_ff + CNT_W'(1)) == count_ff) begin
                  seq_in = SQ_READY;
               end else begin
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
                  seq_in    = SQ_FETCH;
               end
            end
         end

         default: begin
            seq_in = SQ_READY;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // state registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SQ_READY;
         phase_ff     <= PH_HUNT;
         slot_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      id_byte_ff    <= id_byte_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // ---------------------------------------------------------------------
   // frame buffer
   // ---------------------------------------------------------------------
   ilpd_buffer #(
      .DEPTH (MAX_DATA_LEN),
      .AW    (AW)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (mem_re),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   // ---------------------------------------------------------------------
   // outputs
   // ---------------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'b0, rsp_byte_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // table walk never passes the last slot
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SQ_SCAN) |-> (scan_ff < MAX_MSG4))
      else $error("table walk beyond last slot");

   // buffered count stays within the buffer
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_LENC)
      else $error("byte count exceeds buffer depth");

   // delivery runs only after the frame closed, within the buffered bytes
   assert property (@(posedge clock) disable iff (reset)
      ((seq_ff == SQ_FETCH) || (seq_ff == SQ_SEND)) |->
      ((phase_ff == PH_HUNT) && (rd_idx_ff < count_ff)))
      else $error("delivery outside a closed frame");

   // no new input while a delivery or table walk is in progress
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SQ_READY) |-> !req_tready)
      else $error("input accepted while busy");
`endif

endmodule

// File: sim/frame_check_pkg.sv
// ----------------------------------------------------------------------------
// frame_check_pkg: result predictor and checker for the packet deframer
// Tracks the frame parser in step with the block and holds the results it
// still owes; compares each delivered result with the oldest one owed.
// ----------------------------------------------------------------------------
package frame_check_pkg;
   import ilpd_pkg::*;

   localparam int SLOT_LIMIT = 8;
   localparam int DATA_LIMIT = 32;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      status_type status;
      logic [2:0] msg_index;
      logic [7:0] payload;
      logic       last;
   } frame_result_type;

   class frame_scoreboard_type;
      // register copies
      logic [7:0]  sof_byte;
      logic [3:0]  message_count;
      logic [63:0] id_table;
      logic [63:0] length_table;
      logic [15:0] timeout_ticks;

      // parser state
      phase_type   phase;
      logic [2:0]  slot;
      logic [5:0]  byte_count;
      logic [7:0]  running_sum;
      logic [15:0] idle_ticks;
      logic [7:0]  frame_bytes [DATA_LIMIT];

      frame_result_type owed_results [$];
      int mismatches;
      int checked;
      int status_seen [8];

      function new();
         sof_byte      = 8'h00;
         message_count = 4'd0;
         id_table      = 64'd0;
         length_table  = 64'd0;
         timeout_ticks = TIMEOUT_RESET;
         mismatches    = 0;
         checked       = 0;
         back_to_hunt();
      endfunction

      function void set_reg(logic [2:0] index, logic [63:0] value);
         case (index)
            CSR_START_BYTE:    sof_byte      = value[7:0];
            CSR_MESSAGE_COUNT: message_count = value[3:0];
            CSR_ID_TABLE:      id_table      = value;
            CSR_LENGTH_TABLE:  length_table  = value;
            CSR_TIMEOUT_TICKS: timeout_ticks = value[15:0];
            default: ;
         endcase
      endfunction

      function logic [7:0] id_byte(int s);
         return id_table[s*8 +: 8];
      endfunction

      function int slot_length(int s);
         int len;
         len = length_table[s*8 +: 8];
         return (len > DATA_LIMIT) ? DATA_LIMIT : len;
      endfunction

      function void back_to_hunt();
         phase       = PH_HUNT;
         slot        = 3'd0;
         byte_count  = 6'd0;
         running_sum = 8'd0;
         idle_ticks  = 16'd0;
      endfunction

      function void owe(status_type st, logic [2:0] idx, logic [7:0] payload, logic last);
         frame_result_type r;
         r.status    = st;
         r.msg_index = idx;
         r.payload   = payload;
         r.last      = last;
         owed_results.push_back(r);
      endfunction

      // checksum byte: bad sum, empty frame, or the buffered run
      function void close_frame(logic [7:0] b);
         int n;
         n = byte_count;
         if (b != running_sum)
            owe(STAT_BADSUM, slot, 8'h00, 1'b1);
         else if (n == 0)
            owe(STAT_EMPTY, slot, 8'h00, 1'b1);
         else
            for (int i = 0; i < n; i++)
               owe(STAT_DATA, slot, frame_bytes[i], i == n - 1);
         back_to_hunt();
      endfunction

      function void note_input(logic cmd, logic [7:0] b);
         int live;
         int len;
         bit found;
         if (cmd == CMD_TICK) begin
            if (phase == PH_HUNT) return;
            if (int'(idle_ticks) + 1 > int'(timeout_ticks)) begin
               owe(STAT_TIMEOUT, (phase == PH_ID) ? 3'd0 : slot, 8'h00, 1'b1);
               back_to_hunt();
            end else
               idle_ticks++;
            return;
         end
         idle_ticks = 16'd0;
         case (phase)
            PH_HUNT:
               if (b == sof_byte) phase = PH_ID;
            PH_ID: begin
               live  = (message_count > SLOT_LIMIT) ? SLOT_LIMIT : message_count;
               found = 1'b0;
               for (int i = 0; i < live; i++)
                  if (!found && id_byte(i) == b) begin
                     found       = 1'b1;
                     slot        = 3'(i);
                     byte_count  = 6'd0;
                     running_sum = 8'd0;
                     phase       = (slot_length(i) == 0) ? PH_SUM : PH_DATA;
                  end
               if (!found) begin
                  owe(STAT_UNKNOWN, 3'd0, 8'h00, 1'b1);
                  back_to_hunt();
               end
            end
            PH_DATA: begin
               // length is looked up again on every byte
               len = slot_length(slot);
               if (byte_count >= len)
                  close_frame(b);
               else begin
                  frame_bytes[byte_count] = b;
                  byte_count++;
                  running_sum += b;
                  if (byte_count >= len) phase = PH_SUM;
               end
            end
            default:
               close_frame(b);
         endcase
      endfunction

      function void flag_mismatch(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", msg);
      endfunction

      function void check_result(logic [2:0] st, logic [2:0] idx, logic [7:0] payload,
                                 logic last);
         frame_result_type want;
         status_seen[st]++;
         if (owed_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result status %0d idx %0d byte %02h last %0b",
                                    st, idx, payload, last));
            return;
         end
         want = owed_results.pop_front();
         checked++;
         if (st !== want.status || idx !== want.msg_index || payload !== want.payload ||
             last !== want.last)
            flag_mismatch($sformatf(
               "status %0d/%0d idx %0d/%0d byte %02h/%02h last %0b/%0b (got/want)",
               st, want.status, idx, want.msg_index, payload, want.payload,
               last, want.last));
      endfunction
   endclass

endpackage

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for id_length_packet_deframer
// Drives received bytes and ticks with bursty valid and a patterned result
// stall, predicts every result with a frame tracker, checks them in order.
// ----------------------------------------------------------------------------
module tb_top;
   import ilpd_pkg::*;
   import frame_check_pkg::*;

   // ID table walk plus output register, with margin
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASES = 6;

   logic        clock;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] rx_byte
   logic        req_tuser = CMD_BYTE; // [0] command

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [2:0] msg_index, [10:3] payload_byte
   logic [2:0]  rsp_tuser;            // [2:0] status
   logic        rsp_tlast;

   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_START_BYTE;
   logic [63:0] csr_wdata = 64'd0;

   logic [15:0] stall_cycle = 16'd0;

   frame_scoreboard_type sb = new();

   int burst_left = 0;
   int items_sent = 0;
   int settings_used = 0;

   // opening script, {command, byte}; table loaded below:
   //   slot 0 id 00 len 1, slot 1 id 11 len 2, slot 2 id FF len 0,
   //   slot 3 id 11 (shadowed by slot 1), slot 7 id 43 len 3; timeout 2
   logic [8:0] opening_items [28] = '{
      {CMD_BYTE, 8'h3C},                                        // stray byte, dropped
      {CMD_TICK, 8'hFF},                                        // tick while hunting
      {CMD_BYTE, 8'hA5}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'hFF},
      {CMD_BYTE, 8'hFF},                                        // one-byte frame
      {CMD_BYTE, 8'hA5}, {CMD_BYTE, 8'hFF}, {CMD_BYTE, 8'h00},  // zero-length frame
      {CMD_BYTE, 8'hA5}, {CMD_BYTE, 8'h11}, {CMD_BYTE, 8'hA5},
      {CMD_BYTE, 8'h80}, {CMD_BYTE, 8'h00},                     // dup ID, start as data, bad sum
      {CMD_BYTE, 8'hA5}, {CMD_BYTE, 8'h77},                     // unknown ID
      {CMD_BYTE, 8'hA5}, {CMD_TICK, 8'h00}, {CMD_TICK, 8'h00},
      {CMD_TICK, 8'h00},                                        // timeout before the ID
      {CMD_BYTE, 8'hA5}, {CMD_BYTE, 8'h43}, {CMD_TICK, 8'h5A},
      {CMD_TICK, 8'h5A}, {CMD_BYTE, 8'h10}, {CMD_TICK, 8'h5A},
      {CMD_TICK, 8'h5A}, {CMD_TICK, 8'h5A}                      // timeout mid-data
   };

   logic [3:0]  count_plan   [PHASES] = '{4'd8, 4'd1, 4'd8, 4'd6, 4'd3, 4'd0};
   logic [15:0] timeout_plan [PHASES] = '{16'hFFFF, 16'd1, 16'd8, 16'd0, 16'd100, 16'd3};
   int          quota_plan   [PHASES] = '{70, 60, 70, 60, 60, 45};

   id_length_packet_deframer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #4000000;
      $display("tb_top: errors");
      $finish;
   end

   // Both channels are sampled in the active region of the edge, so they
   // read the pre-edge values that the handshake was decided on.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser, rsp_tdata[2:0], rsp_tdata[10:3], rsp_tlast);
      end
   end

   // Result side backpressure: the mode follows bits [8:7] of a free-running counter.
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 16'd1;
      case (stall_cycle[8:7])
         2'd0: rsp_tready <= 1'b1;                          // no stalls
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));      // coin flip
         2'd2: rsp_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
         default: rsp_tready <= stall_cycle[3];             // follows bit 3 of the counter
      endcase
   end

   // One transfer on the input channel. Valid runs in bursts; a gap may
   // open before a burst starts. Returns at the accepting edge.
   task automatic send_item(input logic cmd, input logic [7:0] rx);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   // A few ticks between bytes, never enough to trip the timeout.
   task automatic sprinkle_ticks(input int cap);
      if (cap > 0 && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, cap)) send_item(CMD_TICK, 8'($urandom));
   endtask

   task automatic send_frame(input logic [7:0] id, input int len, input bit bad_sum,
                             input int tick_cap);
      logic [7:0] csum;
      logic [7:0] b;
      csum = 8'h00;
      send_item(CMD_BYTE, sb.sof_byte);
      sprinkle_ticks(tick_cap);
      send_item(CMD_BYTE, id);
      for (int k = 0; k < len; k++) begin
         sprinkle_ticks(tick_cap);
         b = 8'($urandom);
         csum += b;
         send_item(CMD_BYTE, b);
      end
      sprinkle_ticks(tick_cap);
      if (bad_sum) csum += 8'($urandom_range(1, 255));
      send_item(CMD_BYTE, csum);
   endtask

   // Drop valid, wait until every owed result is out, then let the
   // block go quiet (an ID walk may still be running with nothing owed).
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [7:0] start, input logic [3:0] count,
                               input logic [63:0] ids, input logic [63:0] lens,
                               input logic [15:0] tick_limit);
      logic [2:0]  reg_index [5];
      logic [63:0] reg_value [5];
      reg_index = '{CSR_START_BYTE, CSR_MESSAGE_COUNT, CSR_ID_TABLE, CSR_LENGTH_TABLE,
                    CSR_TIMEOUT_TICKS};
      reg_value = '{64'(start), 64'(count), ids, lens, 64'(tick_limit)};
      for (int r = 0; r < 5; r++) begin
         csr_we    <= 1'b1;
         csr_index <= reg_index[r];
         csr_wdata <= reg_value[r];
         @(posedge clock);
         sb.set_reg(reg_index[r], reg_value[r]);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // IDs: random, with some copies of lower slots so duplicates show up
   function automatic logic [63:0] random_ids();
      logic [63:0] t;
      t = 64'd0;
      for (int s = 0; s < 8; s++)
         if (s > 0 && $urandom_range(0, 3) == 0)
            t[s*8 +: 8] = t[$urandom_range(0, s - 1)*8 +: 8];
         else
            t[s*8 +: 8] = 8'($urandom);
      return t;
   endfunction

   // Lengths: mostly short, some empty, a few at or past the 32-byte cap
   function automatic logic [63:0] random_lengths();
      logic [63:0] t;
      int pick;
      for (int s = 0; s < 8; s++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)      t[s*8 +: 8] = 8'd0;
         else if (pick == 1) t[s*8 +: 8] = 8'd32;
         else if (pick == 2) t[s*8 +: 8] = 8'($urandom_range(33, 255));
         else                t[s*8 +: 8] = 8'($urandom_range(1, 6));
      end
      return t;
   endfunction

   // Mostly well-formed frames with random payloads; the rest unknown IDs,
   // bad checksums, line noise and frames left to time out.
   task automatic run_random_phase(input int quota);
      int stop_at;
      int pick;
      int slot;
      int live;
      int tick_cap;
      stop_at  = items_sent + quota;
      live     = (sb.message_count > SLOT_LIMIT) ? SLOT_LIMIT : sb.message_count;
      tick_cap = (sb.timeout_ticks > 3) ? 3 : sb.timeout_ticks;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         slot = (live > 0) ? $urandom_range(0, live - 1) : 0;
         if (live == 0 || pick < 8) begin
            send_item(CMD_BYTE, sb.sof_byte);
            send_item(CMD_BYTE, 8'($urandom));
         end else if (pick < 18) begin
            repeat ($urandom_range(1, 3)) send_item(1'($urandom_range(0, 1)), 8'($urandom));
         end else if (pick < 28 && sb.timeout_ticks <= 20) begin
            send_item(CMD_BYTE, sb.sof_byte);
            if ($urandom_range(0, 2) != 0) begin
               send_item(CMD_BYTE, sb.id_byte(slot));
               repeat ($urandom_range(0, sb.slot_length(slot)))
                  send_item(CMD_BYTE, 8'($urandom));
            end
            repeat (int'(sb.timeout_ticks) + 1) send_item(CMD_TICK, 8'($urandom));
         end else begin
            send_frame(sb.id_byte(slot), sb.slot_length(slot), $urandom_range(0, 6) == 0,
                       tick_cap);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: start byte 00 and an empty table, so 00 00 is an unknown ID
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_BYTE, 8'h00);
      settle();

      program_regs(8'hA5, 4'd8, 64'h4342_4140_11FF_1100, 64'h0320_21FF_0500_0201, 16'd2);
      foreach (opening_items[i]) send_item(opening_items[i][8], opening_items[i][7:0]);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         program_regs((p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom),
                      count_plan[p], random_ids(),
                      (p == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : random_lengths(),
                      timeout_plan[p]);
         run_random_phase(quota_plan[p]);
      end
      settle();

      $display("tb_top: %0d input transfers, %0d results checked, %0d register settings",
               items_sent, sb.checked, settings_used);
      $display("tb_top: data %0d, empty %0d, bad checksum %0d, unknown id %0d, timeout %0d",
               sb.status_seen[STAT_DATA], sb.status_seen[STAT_EMPTY],
               sb.status_seen[STAT_BADSUM], sb.status_seen[STAT_UNKNOWN],
               sb.status_seen[STAT_TIMEOUT]);
      if (sb.mismatches == 0 && sb.owed_results.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
